FILE: rtl/core/tbci_pkg.sv
// ----------------------------------------------------------------------------
// tbci_pkg
// Types and fixed widths shared by the two-body contact impulse pipeline.
// ----------------------------------------------------------------------------
package tbci_pkg;

    localparam int VEL_W   = 32;
    localparam int NRM_W   = 16;
    localparam int MASS_W  = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;
    localparam int TOT_W   = MASS_W + 1;
    localparam int QUO_W   = 38;            // widest weighted quotient
    localparam int DEN_W   = TOT_W;
    localparam int NUM_W   = QUO_W + DEN_W;
    localparam int LANES   = 6;             // 3 position + 3 velocity lanes

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_SLOP_DEPTH    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CORR_FRACTION = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RESTITUTION   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_RESTING_SPEED = 2'd3;

    localparam logic [15:0] SLOP_RST  = 16'd655;
    localparam logic [15:0] CORR_RST  = 16'd52429;
    localparam logic [15:0] REST_RST  = 16'd58982;
    localparam logic [23:0] SPEED_RST = 24'd21430;

    typedef struct packed {
        logic        [MASS_W-1:0] inv_mass_a;
        logic        [MASS_W-1:0] inv_mass_b;
        logic signed [NRM_W-1:0]  normal_x;
        logic signed [NRM_W-1:0]  normal_y;
        logic signed [NRM_W-1:0]  normal_z;
        logic        [MASS_W-1:0] depth;
        logic signed [VEL_W-1:0]  vel_a_x;
        logic signed [VEL_W-1:0]  vel_a_y;
        logic signed [VEL_W-1:0]  vel_a_z;
        logic signed [VEL_W-1:0]  vel_b_x;
        logic signed [VEL_W-1:0]  vel_b_y;
        logic signed [VEL_W-1:0]  vel_b_z;
    } in_item_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] shift_a_x;
        logic signed [VEL_W-1:0] shift_a_y;
        logic signed [VEL_W-1:0] shift_a_z;
        logic signed [VEL_W-1:0] shift_b_x;
        logic signed [VEL_W-1:0] shift_b_y;
        logic signed [VEL_W-1:0] shift_b_z;
        logic signed [VEL_W-1:0] new_vel_a_x;
        logic signed [VEL_W-1:0] new_vel_a_y;
        logic signed [VEL_W-1:0] new_vel_a_z;
        logic signed [VEL_W-1:0] new_vel_b_x;
        logic signed [VEL_W-1:0] new_vel_b_y;
        logic signed [VEL_W-1:0] new_vel_b_z;
    } out_item_t;

endpackage

FILE: rtl/core/tbci_div.sv
// ----------------------------------------------------------------------------
// tbci_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module tbci_div #(
    parameter int QW = 38,
    parameter int DW = 25
) (
    input  logic             clk,
    input  logic             en,
    input  logic [QW+DW-1:0] num,
    input  logic [DW-1:0]    den,
    output logic [QW-1:0]    quo,
    output logic [DW-1:0]    rem
);

    localparam int NW = QW + DW;

    logic [DW-1:0] rem_reg  [1:QW];
    logic [QW-1:0] lq_reg   [1:QW];
    logic [DW-1:0] den_reg  [1:QW];
    logic [DW-1:0] rem_next [1:QW];
    logic [QW-1:0] lq_next  [1:QW];
    logic [DW-1:0] den_next [1:QW];

    always_comb
    begin
        logic [DW-1:0] r;
        logic [QW-1:0] l;
        logic [DW-1:0] d;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        for (int k = 1; k <= QW; k++)
        begin
            if (k == 1)
            begin
                r = num[NW-1:QW];
                l = num[QW-1:0];
                d = den;
            end
            else
            begin
                r = rem_reg[k-1];
                l = lq_reg[k-1];
                d = den_reg[k-1];
            end
            // low dividend bits shift out as quotient bits shift in
            trial = {r, l[QW-1]};
            diff  = trial - {1'b0, d};
            if (trial >= {1'b0, d})
            begin
                rem_next[k] = diff[DW-1:0];
                lq_next[k]  = {l[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[DW-1:0];
                lq_next[k]  = {l[QW-2:0], 1'b0};
            end
            den_next[k] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            lq_reg  <= lq_next;
            den_reg <= den_next;
        end
    end

    assign quo = lq_reg[QW];
    assign rem = rem_reg[QW];

endmodule

FILE: rtl/core/two_body_contact_impulse.sv
// ----------------------------------------------------------------------------
// two_body_contact_impulse
// Position correction and restitution impulse for one two-body contact.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one contact per transaction (valid/ready), in_item_t payload.
//   out_* : one result per contact, out_item_t payload, in contact order.
//   cfg_* : register writes (index, data); always ready. Write only while
//           the pipeline is empty.
// Throughput: one contact per cycle, sustained while out_ready does not stall the pipeline.
// Depth: the pipeline depth is set by the multiply chain (depth*fraction, normal
//   dot product, restitution, per-axis scaling, inverse-mass weighting) followed
//   by a 38-stage one-bit-per-stage divider for the inverse-mass split.
// Stall: the whole pipeline holds while a result waits on out_ready; nothing
//   is dropped or repeated, bubbles travel as cleared valid bits.
// Reset: valid bits clear, registers return to their defaults
//   (slop 0.01, fraction 0.8, restitution 0.9).
// Body B's share is derived from body A's quotient and remainder, so one
// divider per lane serves both bodies.
// ----------------------------------------------------------------------------
module two_body_contact_impulse (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tbci_pkg::in_item_t        in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output tbci_pkg::out_item_t       out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tbci_pkg::IDX_W-1:0] cfg_index,
    input  logic [tbci_pkg::CFG_W-1:0] cfg_data
);

    import tbci_pkg::*;

    // stage numbers
    localparam int ST_C       = 5;               // position magnitudes ready
    localparam int ST_E       = 6;               // approach flag ready
    localparam int ST_P       = 10;              // velocity magnitudes ready
    localparam int ST_DIV_IN  = 12;
    localparam int ST_DIV_OUT = ST_DIV_IN + QUO_W;
    localparam int ST_F1      = ST_DIV_OUT + 1;
    localparam int ST_OUT     = ST_F1 + 1;
    localparam int DELTA_W    = QUO_W + 2;

    typedef struct packed {
        logic [2:0][VEL_W-1:0]        va;
        logic [2:0][VEL_W-1:0]        vb;
        logic [2:0][NRM_W-1:0]        n;
        logic [MASS_W-1:0]            inv_a;
        logic [TOT_W-1:0]             total;
        logic                         pos;     // apply position correction
        logic                         appr;    // apply impulse
        logic [LANES-1:0][QUO_W-1:0]  along;   // magnitude to be weighted
    } ctx_t;

    // configuration
    logic [15:0] slop_reg;
    logic [15:0] corr_reg;
    logic [15:0] rest_reg;
    logic [23:0] speed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slop_reg  <= SLOP_RST;
            corr_reg  <= CORR_RST;
            rest_reg  <= REST_RST;
            speed_reg <= SPEED_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SLOP_DEPTH:    slop_reg  <= cfg_data[15:0];
                CFG_CORR_FRACTION: corr_reg  <= cfg_data[15:0];
                CFG_RESTITUTION:   rest_reg  <= cfg_data[15:0];
                CFG_RESTING_SPEED: speed_reg <= cfg_data[23:0];
                default:           ;
            endcase
        end
    end

    function automatic logic [NRM_W-1:0] mag16(input logic [NRM_W-1:0] v);
        return v[NRM_W-1] ? NRM_W'(-$signed(v)) : v;
    endfunction

    function automatic logic [VEL_W-1:0] sat32(input logic signed [VEL_W+8:0] v);
        if (v > 41'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -41'sd2147483648)
            return 32'h8000_0000;
        else
            return v[VEL_W-1:0];
    endfunction

    // pipeline control: global hold while the output waits
    logic              pipe_en;
    logic [ST_OUT:0]   vld_reg;

    assign pipe_en   = !vld_reg[ST_OUT] || out_ready;
    assign in_ready  = pipe_en;
    assign out_valid = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= {vld_reg[ST_OUT-1:0], in_valid};
    end

    // datapath registers
    in_item_t                     in0_reg;
    logic [MASS_W-1:0]            exc1_reg;
    logic [2:0][VEL_W:0]          diff1_reg;
    logic [39:0]                  aprod2_reg;
    logic [2:0][48:0]             vprod2_reg;
    logic [MASS_W:0]              amt3_reg;
    logic [50:0]                  s3_reg;
    logic [2:0][40:0]             cprod4_reg;
    logic [49:0]                  smag4_reg;
    logic                         sneg4_reg;
    logic [35:0]                  vmag5_reg;
    logic                         appr5_reg;
    logic [15:0]                  e6_reg;
    logic [35:0]                  vmag6_reg;
    logic [52:0]                  mprod7_reg;
    logic [36:0]                  m8_reg;
    logic [2:0][52:0]             pprod9_reg;
    logic [LANES-1:0][49:0]       pl11_reg;
    logic [LANES-1:0][49:0]       ph11_reg;
    logic [LANES-1:0][NUM_W-1:0]  num12_reg;
    logic [LANES-1:0][DELTA_W-1:0] da51_reg;
    logic [LANES-1:0][DELTA_W-1:0] db51_reg;
    out_item_t                    out_reg;
    ctx_t                         ctx_reg  [1:ST_F1];
    ctx_t                         ctx_next [1:ST_F1];

    logic [LANES-1:0][QUO_W-1:0]  quo;
    logic [LANES-1:0][DEN_W-1:0]  rem;
    logic [LANES-1:0][DELTA_W-1:0] da_next;
    logic [LANES-1:0][DELTA_W-1:0] db_next;
    out_item_t                    out_next;
    logic                         div_ok;

    // side data travels with each contact; fields are filled as they appear
    always_comb
    begin
        ctx_next[1].va    = {in0_reg.vel_a_z, in0_reg.vel_a_y, in0_reg.vel_a_x};
        ctx_next[1].vb    = {in0_reg.vel_b_z, in0_reg.vel_b_y, in0_reg.vel_b_x};
        ctx_next[1].n     = {in0_reg.normal_z, in0_reg.normal_y, in0_reg.normal_x};
        ctx_next[1].inv_a = in0_reg.inv_mass_a;
        ctx_next[1].total = TOT_W'(in0_reg.inv_mass_a) + TOT_W'(in0_reg.inv_mass_b);
        ctx_next[1].pos   = (ctx_next[1].total != '0) &&
                            (in0_reg.depth > MASS_W'(slop_reg));
        ctx_next[1].appr  = 1'b0;
        ctx_next[1].along = '0;
        for (int k = 2; k <= ST_F1; k++)
            ctx_next[k] = ctx_reg[k-1];
        for (int i = 0; i < 3; i++)
        begin
            ctx_next[ST_C].along[i]   = QUO_W'((cprod4_reg[i] + 41'd8192) >> 14);
            ctx_next[ST_P].along[3+i] = QUO_W'((pprod9_reg[i] + 53'd8192) >> 14);
        end
        ctx_next[ST_E].appr = appr5_reg && (vmag5_reg != '0) &&
                              (ctx_reg[ST_E-1].total != '0);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            in0_reg  <= in_data;
            ctx_reg  <= ctx_next;
            // depth excess and relative velocity
            exc1_reg <= in0_reg.depth - MASS_W'(slop_reg);
            diff1_reg[0] <= (VEL_W+1)'(in0_reg.vel_b_x) - (VEL_W+1)'(in0_reg.vel_a_x);
            diff1_reg[1] <= (VEL_W+1)'(in0_reg.vel_b_y) - (VEL_W+1)'(in0_reg.vel_a_y);
            diff1_reg[2] <= (VEL_W+1)'(in0_reg.vel_b_z) - (VEL_W+1)'(in0_reg.vel_a_z);
            aprod2_reg <= 40'(exc1_reg) * 40'(corr_reg);
            for (int i = 0; i < 3; i++)
                vprod2_reg[i] <= 49'($signed(diff1_reg[i])) *
                                 49'($signed(ctx_reg[1].n[i]));
            amt3_reg <= (MASS_W+1)'((aprod2_reg + 40'd32768) >> 16);
            s3_reg   <= 51'($signed(vprod2_reg[0])) + 51'($signed(vprod2_reg[1])) +
                        51'($signed(vprod2_reg[2]));
            for (int i = 0; i < 3; i++)
                cprod4_reg[i] <= 41'(amt3_reg) * 41'(mag16(ctx_reg[3].n[i]));
            sneg4_reg <= s3_reg[50];
            smag4_reg <= s3_reg[50] ? 50'(-$signed(s3_reg)) : s3_reg[49:0];
            vmag5_reg <= 36'((smag4_reg + 50'd8192) >> 14);
            appr5_reg <= sneg4_reg;
            // restitution drops out below the resting speed
            e6_reg    <= (vmag5_reg < 36'(speed_reg)) ? 16'd0 : rest_reg;
            vmag6_reg <= vmag5_reg;
            mprod7_reg <= 53'(17'h1_0000 + 17'(e6_reg)) * 53'(vmag6_reg);
            m8_reg     <= 37'((mprod7_reg + 53'd32768) >> 16);
            for (int i = 0; i < 3; i++)
                pprod9_reg[i] <= 53'(m8_reg) * 53'(mag16(ctx_reg[8].n[i]));
            // numerator = along * inv_a + total/2, split multiply
            for (int j = 0; j < LANES; j++)
            begin
                pl11_reg[j] <= 50'(ctx_reg[10].along[j]) * 50'(ctx_reg[10].inv_a[11:0]);
                ph11_reg[j] <= 50'(ctx_reg[10].along[j]) * 50'(ctx_reg[10].inv_a[23:12]);
                num12_reg[j] <= (NUM_W'(ph11_reg[j]) << 12) + NUM_W'(pl11_reg[j]) +
                                NUM_W'(ctx_reg[11].total >> 1);
            end
            da51_reg <= da_next;
            db51_reg <= db_next;
            out_reg  <= out_next;
        end
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_div
        tbci_div #(
            .QW (QUO_W),
            .DW (DEN_W)
        ) u_div (
            .clk (clk),
            .en  (pipe_en),
            .num (num12_reg[j]),
            .den (ctx_reg[ST_DIV_IN].total),
            .quo (quo[j]),
            .rem (rem[j])
        );
    end

    // B share: along - qa, plus one when total is even and the remainder is 0
    always_comb
    begin
        logic [DELTA_W-1:0] qa;
        logic [DELTA_W-1:0] qb;
        logic               bump;
        logic               neg;
        div_ok = 1'b1;
        for (int j = 0; j < LANES; j++)
        begin
            bump = !ctx_reg[ST_DIV_OUT].total[0] && (rem[j] == '0);
            qa   = DELTA_W'(quo[j]);
            qb   = DELTA_W'(ctx_reg[ST_DIV_OUT].along[j]) - qa + DELTA_W'(bump);
            neg  = ctx_reg[ST_DIV_OUT].n[(j < 3) ? j : j - 3][NRM_W-1];
            da_next[j] = neg ? qa : DELTA_W'(-$signed(qa));
            db_next[j] = neg ? DELTA_W'(-$signed(qb)) : qb;
            div_ok = div_ok && (quo[j] <= ctx_reg[ST_DIV_OUT].along[j]) &&
                     (rem[j] < ctx_reg[ST_DIV_OUT].total);
        end
    end

    always_comb
    begin
        logic [2:0][VEL_W-1:0] sa;
        logic [2:0][VEL_W-1:0] sb;
        logic [2:0][VEL_W-1:0] nva;
        logic [2:0][VEL_W-1:0] nvb;
        for (int i = 0; i < 3; i++)
        begin
            sa[i] = ctx_reg[ST_F1].pos ? sat32(41'($signed(da51_reg[i]))) : '0;
            sb[i] = ctx_reg[ST_F1].pos ? sat32(41'($signed(db51_reg[i]))) : '0;
            nva[i] = ctx_reg[ST_F1].appr ?
                     sat32(41'($signed(ctx_reg[ST_F1].va[i])) +
                           41'($signed(da51_reg[3+i]))) :
                     ctx_reg[ST_F1].va[i];
            nvb[i] = ctx_reg[ST_F1].appr ?
                     sat32(41'($signed(ctx_reg[ST_F1].vb[i])) +
                           41'($signed(db51_reg[3+i]))) :
                     ctx_reg[ST_F1].vb[i];
        end
        out_next.shift_a_x   = sa[0];
        out_next.shift_a_y   = sa[1];
        out_next.shift_a_z   = sa[2];
        out_next.shift_b_x   = sb[0];
        out_next.shift_b_y   = sb[1];
        out_next.shift_b_z   = sb[2];
        out_next.new_vel_a_x = nva[0];
        out_next.new_vel_a_y = nva[1];
        out_next.new_vel_a_z = nva[2];
        out_next.new_vel_b_x = nvb[0];
        out_next.new_vel_b_y = nvb[1];
        out_next.new_vel_b_z = nvb[2];
    end

    assign out_data = out_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIV_OUT] && (ctx_reg[ST_DIV_OUT].pos || ctx_reg[ST_DIV_OUT].appr)
        |-> ctx_reg[ST_DIV_OUT].total != '0)
        else $error("correction enabled with zero total inverse mass");

    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DIV_OUT] && (ctx_reg[ST_DIV_OUT].total != '0) |-> div_ok)
        else $error("divider result out of range or misaligned");

endmodule
